// ----- sv/lfu_pkg.sv -----
// Shared types, codes and defaults for the LFU block cache controller.
package lfu_pkg;

    localparam int MAX_ENTRIES_DEF     = 256;
    localparam int BLOCK_WORDS_DEF     = 32;
    localparam int NUM_DISKS_DEF       = 16;
    localparam int BLOCKS_PER_DISK_DEF = 256;
    localparam int MIN_ENTRIES         = 2;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES  = 1'b1;

    typedef enum logic [1:0] {
        OP_STAGE  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_INSERT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_OFF  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_IDX,
        SEL_TARGET
    } slot_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INS,
        S_CRD,
        S_CWR,
        S_WRD,
        S_WLD,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  disk;
        logic [7:0]  block;
        logic [4:0]  word_index;
        logic [63:0] data_word;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] read_word;
        logic        last;
        logic [7:0]  slot;
        logic [31:0] query_count;
        logic [31:0] hit_count;
    } rsp_t;

    typedef struct packed {
        logic      idle;
        logic      stage_write;
        logic      count_query;
        logic      scan_start;
        logic      scan_read;
        logic      scan_eval;
        logic      hit_take;
        logic      ins_take;
        logic      blk_read;
        logic      stg_read;
        logic      blk_write;
        logic      word_next;
        logic      emit;
        logic      emit_word;
        logic      set_res;
        status_t   res_status;
        slot_sel_t res_slot;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic in_fire;
        logic cache_on;
        logic key_ok;
        logic slot_valid;
        logic key_match;
        logic scan_last;
        logic word_last;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/lfu_ctrl.sv -----
// Controller state machine: sequences decode, slot scan, block copy and result output.
module lfu_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  lfu_pkg::stat_t stat,
    output lfu_pkg::cmd_t  cmd
);

    lfu_pkg::ctrl_state_t state_reg;
    lfu_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfu_pkg::S_IDLE:
            begin
                if (stat.in_fire)
                begin
                    state_next = lfu_pkg::S_DECODE;
                end
            end
            lfu_pkg::S_DECODE:
            begin
                if (stat.op == lfu_pkg::OP_STAGE || !stat.cache_on || !stat.key_ok)
                begin
                    state_next = lfu_pkg::S_RESULT;
                end
                else
                begin
                    state_next = lfu_pkg::S_SCAN_RD;
                end
            end
            lfu_pkg::S_SCAN_RD:
            begin
                state_next = lfu_pkg::S_SCAN_CMP;
            end
            lfu_pkg::S_SCAN_CMP:
            begin
                case (stat.op)
                    lfu_pkg::OP_LOOKUP:
                    begin
                        if (!stat.slot_valid || stat.scan_last)
                        begin
                            state_next = lfu_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = lfu_pkg::S_SCAN_RD;
                        end
                        if (stat.slot_valid && stat.key_match)
                        begin
                            state_next = lfu_pkg::S_WRD;
                        end
                    end
                    lfu_pkg::OP_UPDATE:
                    begin
                        if (stat.slot_valid && stat.key_match)
                        begin
                            state_next = lfu_pkg::S_CRD;
                        end
                        else if (stat.scan_last)
                        begin
                            state_next = lfu_pkg::S_RESULT;
                        end
                        else
                        begin
                            state_next = lfu_pkg::S_SCAN_RD;
                        end
                    end
                    lfu_pkg::OP_INSERT:
                    begin
                        if (stat.slot_valid && stat.key_match)
                        begin
                            state_next = lfu_pkg::S_RESULT;
                        end
                        else if (stat.scan_last)
                        begin
                            state_next = lfu_pkg::S_INS;
                        end
                        else
                        begin
                            state_next = lfu_pkg::S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = lfu_pkg::S_RESULT;
                    end
                endcase
            end
            lfu_pkg::S_INS:
            begin
                state_next = lfu_pkg::S_CRD;
            end
            lfu_pkg::S_CRD:
            begin
                state_next = lfu_pkg::S_CWR;
            end
            lfu_pkg::S_CWR:
            begin
                state_next = stat.word_last ? lfu_pkg::S_RESULT : lfu_pkg::S_CRD;
            end
            lfu_pkg::S_WRD:
            begin
                state_next = lfu_pkg::S_WLD;
            end
            lfu_pkg::S_WLD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.word_last ? lfu_pkg::S_IDLE : lfu_pkg::S_WRD;
                end
            end
            lfu_pkg::S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = lfu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = lfu_pkg::ST_OK;
        cmd.res_slot   = lfu_pkg::SEL_ZERO;
        case (state_reg)
            lfu_pkg::S_IDLE:
            begin
                cmd.idle = 1'b1;
            end
            lfu_pkg::S_DECODE:
            begin
                cmd.set_res = 1'b1;
                if (stat.op == lfu_pkg::OP_STAGE)
                begin
                    cmd.stage_write = 1'b1;
                    cmd.res_status  = lfu_pkg::ST_OK;
                end
                else if (!stat.cache_on)
                begin
                    cmd.res_status = lfu_pkg::ST_OFF;
                end
                else if (!stat.key_ok)
                begin
                    cmd.res_status = lfu_pkg::ST_MISS;
                end
                else
                begin
                    cmd.set_res     = 1'b0;
                    cmd.scan_start  = 1'b1;
                    cmd.count_query = (stat.op == lfu_pkg::OP_LOOKUP);
                end
            end
            lfu_pkg::S_SCAN_RD:
            begin
                cmd.scan_read = 1'b1;
            end
            lfu_pkg::S_SCAN_CMP:
            begin
                if (stat.slot_valid && stat.key_match)
                begin
                    if (stat.op == lfu_pkg::OP_INSERT)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = lfu_pkg::ST_DUP;
                        cmd.res_slot   = lfu_pkg::SEL_IDX;
                    end
                    else
                    begin
                        cmd.hit_take = 1'b1;
                    end
                end
                else if (stat.op == lfu_pkg::OP_LOOKUP && (!stat.slot_valid || stat.scan_last))
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = lfu_pkg::ST_MISS;
                end
                else if (stat.op == lfu_pkg::OP_UPDATE && stat.scan_last)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = lfu_pkg::ST_MISS;
                end
                else
                begin
                    cmd.scan_eval = 1'b1;
                end
            end
            lfu_pkg::S_INS:
            begin
                cmd.ins_take = 1'b1;
            end
            lfu_pkg::S_CRD:
            begin
                cmd.stg_read = 1'b1;
            end
            lfu_pkg::S_CWR:
            begin
                cmd.blk_write = 1'b1;
                cmd.word_next = 1'b1;
                if (stat.word_last)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = lfu_pkg::ST_OK;
                    cmd.res_slot   = lfu_pkg::SEL_TARGET;
                end
            end
            lfu_pkg::S_WRD:
            begin
                cmd.blk_read = 1'b1;
            end
            lfu_pkg::S_WLD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_word = 1'b1;
                    cmd.word_next = 1'b1;
                end
            end
            lfu_pkg::S_RESULT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd.idle = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/lfu_dp.sv -----
// Datapath: request and config registers, slot tables, block store, staging buffer, output register.
module lfu_dp
#(
    parameter int MAX_ENTRIES     = lfu_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_WORDS     = lfu_pkg::BLOCK_WORDS_DEF,
    parameter int NUM_DISKS       = lfu_pkg::NUM_DISKS_DEF,
    parameter int BLOCKS_PER_DISK = lfu_pkg::BLOCKS_PER_DISK_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  lfu_pkg::req_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output lfu_pkg::rsp_t                    out_data,
    input  logic                             cfg_we,
    input  logic [lfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  lfu_pkg::cmd_t                    cmd,
    output lfu_pkg::stat_t                   stat
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int KW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int AW = $clog2(MAX_ENTRIES * BLOCK_WORDS);
    localparam logic [AW-1:0] BW_A  = AW'(BLOCK_WORDS);
    localparam logic [KW-1:0] K_END = KW'(BLOCK_WORDS - 1);

    lfu_pkg::req_t req_reg;
    logic          cache_on_reg;
    logic [8:0]    entries_reg;
    logic [31:0]   query_reg;
    logic [31:0]   hit_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;

    logic [3:0]  disk_mem  [MAX_ENTRIES];
    logic [7:0]  block_mem [MAX_ENTRIES];
    logic [31:0] uses_mem  [MAX_ENTRIES];
    logic [63:0] blk_mem   [MAX_ENTRIES * BLOCK_WORDS];
    logic [63:0] stg_mem   [BLOCK_WORDS];

    logic [3:0]    disk_rd;
    logic [7:0]    block_rd;
    logic [31:0]   uses_rd;
    logic          valid_rd;
    logic [63:0]   blk_rd;
    logic [63:0]   stg_rd;

    logic [SW-1:0] idx_reg;
    logic [SW-1:0] target_reg;
    logic [SW-1:0] empty_reg;
    logic [SW-1:0] victim_reg;
    logic          have_empty_reg;
    logic          have_best_reg;
    logic [31:0]   best_reg;
    logic [KW-1:0] k_reg;

    lfu_pkg::status_t res_status_reg;
    logic [7:0]       res_slot_reg;
    logic             out_valid_reg;
    lfu_pkg::rsp_t    out_reg;

    logic [31:0]   last_idx;
    logic [SW-1:0] ins_slot;
    logic [AW-1:0] blk_addr;
    logic          out_free;

    always_comb
    begin
        last_idx = 32'(entries_reg);
        if (last_idx < 32'(lfu_pkg::MIN_ENTRIES))
        begin
            last_idx = 32'(lfu_pkg::MIN_ENTRIES);
        end
        if (last_idx > 32'(MAX_ENTRIES))
        begin
            last_idx = 32'(MAX_ENTRIES);
        end
        last_idx = last_idx - 32'd1;
    end

    assign ins_slot = have_empty_reg ? empty_reg : victim_reg;
    assign blk_addr = AW'(target_reg) * BW_A + AW'(k_reg);
    assign out_free = !out_valid_reg || !out_stall;

    assign stat.op         = req_reg.op;
    assign stat.in_fire    = in_valid && cmd.idle;
    assign stat.cache_on   = cache_on_reg;
    assign stat.key_ok     = (32'(req_reg.disk) < 32'(NUM_DISKS))
                          && (32'(req_reg.block) < 32'(BLOCKS_PER_DISK));
    assign stat.slot_valid = valid_rd;
    assign stat.key_match  = (disk_rd == req_reg.disk) && (block_rd == req_reg.block);
    assign stat.scan_last  = (idx_reg == SW'(last_idx));
    assign stat.word_last  = (k_reg == K_END);
    assign stat.out_free   = out_free;

    // request capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && cmd.idle)
        begin
            req_reg <= in_data;
        end
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_on_reg <= 1'b0;
            entries_reg  <= 9'(lfu_pkg::MIN_ENTRIES);
            query_reg    <= '0;
            hit_reg      <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == lfu_pkg::CFG_CACHE_ON)
            begin
                cache_on_reg <= cfg_data[0];
                query_reg    <= '0;
                hit_reg      <= '0;
                valid_reg    <= '0;
            end
            if (cfg_we && cfg_index == lfu_pkg::CFG_ENTRIES)
            begin
                entries_reg <= cfg_data;
            end
            if (cmd.count_query && query_reg != 32'hFFFF_FFFF)
            begin
                query_reg <= query_reg + 32'd1;
            end
            if (cmd.hit_take && req_reg.op == lfu_pkg::OP_LOOKUP
                && hit_reg != 32'hFFFF_FFFF)
            begin
                hit_reg <= hit_reg + 32'd1;
            end
            if (cmd.ins_take)
            begin
                valid_reg[ins_slot] <= 1'b1;
            end
        end
    end

    // scan and copy bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            idx_reg        <= '0;
            have_empty_reg <= 1'b0;
            have_best_reg  <= 1'b0;
        end
        if (cmd.scan_eval)
        begin
            idx_reg <= idx_reg + SW'(1);
            if (valid_rd)
            begin
                if (!have_best_reg || uses_rd < best_reg)
                begin
                    have_best_reg <= 1'b1;
                    best_reg      <= uses_rd;
                    victim_reg    <= idx_reg;
                end
            end
            else if (!have_empty_reg)
            begin
                have_empty_reg <= 1'b1;
                empty_reg      <= idx_reg;
            end
        end
        if (cmd.hit_take)
        begin
            target_reg <= idx_reg;
            k_reg      <= '0;
        end
        if (cmd.ins_take)
        begin
            target_reg <= ins_slot;
            k_reg      <= '0;
        end
        if (cmd.word_next)
        begin
            k_reg <= k_reg + KW'(1);
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_slot)
                lfu_pkg::SEL_IDX:    res_slot_reg <= 8'(idx_reg);
                lfu_pkg::SEL_TARGET: res_slot_reg <= 8'(target_reg);
                default:             res_slot_reg <= 8'd0;
            endcase
        end
    end

    // slot tables
    always_ff @(posedge clk)
    begin
        if (cmd.scan_read)
        begin
            disk_rd  <= disk_mem[idx_reg];
            block_rd <= block_mem[idx_reg];
            uses_rd  <= uses_mem[idx_reg];
            valid_rd <= valid_reg[idx_reg];
        end
        if (cmd.hit_take)
        begin
            uses_mem[idx_reg] <= (uses_rd == 32'hFFFF_FFFF) ? uses_rd : uses_rd + 32'd1;
        end
        if (cmd.ins_take)
        begin
            uses_mem[ins_slot]  <= 32'd1;
            disk_mem[ins_slot]  <= req_reg.disk;
            block_mem[ins_slot] <= req_reg.block;
        end
    end

    // staging buffer
    always_ff @(posedge clk)
    begin
        if (cmd.stage_write && 32'(req_reg.word_index) < 32'(BLOCK_WORDS))
        begin
            stg_mem[KW'(req_reg.word_index)] <= req_reg.data_word;
        end
        if (cmd.stg_read)
        begin
            stg_rd <= stg_mem[k_reg];
        end
    end

    // block store
    always_ff @(posedge clk)
    begin
        if (cmd.blk_write)
        begin
            blk_mem[blk_addr] <= stg_rd;
        end
        if (cmd.blk_read)
        begin
            blk_rd <= blk_mem[blk_addr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.query_count <= query_reg;
            out_reg.hit_count   <= hit_reg;
            if (cmd.emit_word)
            begin
                out_reg.status    <= lfu_pkg::ST_OK;
                out_reg.read_word <= blk_rd;
                out_reg.last      <= (k_reg == K_END);
                out_reg.slot      <= 8'(target_reg);
            end
            else
            begin
                out_reg.status    <= res_status_reg;
                out_reg.read_word <= 64'd0;
                out_reg.last      <= 1'b1;
                out_reg.slot      <= res_slot_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/lfu_block_cache_controller_unit.sv -----
// LFU block cache controller: top level joining the controller and the datapath.
// Requests enter on in_valid/in_stall with an lfu_pkg::req_t payload; one request
// is worked at a time and in_stall stays high until its last result is loaded.
// Results leave on out_valid/out_stall as lfu_pkg::rsp_t; a lookup hit gives
// BLOCK_WORDS results, the last one flagged, every other request gives one.
// Stage, disabled and out-of-range requests go from decode straight to the
// result state. Lookup, update and insert scan the slot table slot by slot
// (registered table read, then compare), over at most the configured slot count;
// a lookup hit then reads the block store word by word, and update or insert
// copy the staging buffer into the block store word by word.
// Both the slot table and the block store are single-port.
// The output register frees the core as soon as a result is taken; while
// out_stall is high the result holds and the sequencer waits before the next.
// Reset clears the cache-enable, slot valid marks and totals and sets the slot
// count to 2. Writing cache_on clears all valid marks and both totals.
module lfu_block_cache_controller_unit
#(
    parameter int MAX_ENTRIES     = lfu_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_WORDS     = lfu_pkg::BLOCK_WORDS_DEF,
    parameter int NUM_DISKS       = lfu_pkg::NUM_DISKS_DEF,
    parameter int BLOCKS_PER_DISK = lfu_pkg::BLOCKS_PER_DISK_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lfu_pkg::req_t                  in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lfu_pkg::rsp_t                  out_data,
    input  logic                           cfg_we,
    input  logic [lfu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfu_pkg::CFG_DATA_W-1:0] cfg_data
);

    lfu_pkg::cmd_t  cmd;
    lfu_pkg::stat_t stat;

    assign in_stall = !cmd.idle;

    lfu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    lfu_dp
    #(
        .MAX_ENTRIES     (MAX_ENTRIES),
        .BLOCK_WORDS     (BLOCK_WORDS),
        .NUM_DISKS       (NUM_DISKS),
        .BLOCKS_PER_DISK (BLOCKS_PER_DISK)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- tb/lfu_block_cache_controller_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LFU block cache controller top level.
module lfu_block_cache_controller_unit_tb;

    localparam int SLOTS = lfu_pkg::MAX_ENTRIES_DEF;
    localparam int WORDS = lfu_pkg::BLOCK_WORDS_DEF;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    lfu_pkg::req_t in_data;
    logic out_valid;
    logic out_stall;
    lfu_pkg::rsp_t out_data;
    logic cfg_we;
    logic [lfu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lfu_pkg::CFG_DATA_W-1:0] cfg_data;

    lfu_block_cache_controller_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the cache
    logic        shadow_on;
    logic [8:0]  shadow_entries;
    logic        shadow_valid [SLOTS];
    logic [3:0]  shadow_disk [SLOTS];
    logic [7:0]  shadow_block [SLOTS];
    logic [31:0] shadow_uses [SLOTS];
    logic [63:0] shadow_store [SLOTS][WORDS];
    logic [63:0] shadow_staging [WORDS];
    logic [31:0] shadow_lookups;
    logic [31:0] shadow_hits;

    lfu_pkg::rsp_t pending_rsp [$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   mismatches;
    int   requests_sent;
    int   results_seen;
    int   hit_results;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void push_rsp(lfu_pkg::status_t st, logic [63:0] w, logic lst, int s);
        lfu_pkg::rsp_t r;
        r.status      = st;
        r.read_word   = w;
        r.last        = lst;
        r.slot        = s[7:0];
        r.query_count = shadow_lookups;
        r.hit_count   = shadow_hits;
        pending_rsp.push_back(r);
    endfunction

    function automatic void predict_cache(lfu_pkg::req_t r);
        int  n;
        int  victim;
        int  empty;
        int  target;
        bit  have_empty;
        n = shadow_entries;
        if (n < lfu_pkg::MIN_ENTRIES) n = lfu_pkg::MIN_ENTRIES;
        if (n > SLOTS) n = SLOTS;
        if (r.op == lfu_pkg::OP_STAGE)
        begin
            shadow_staging[r.word_index] = r.data_word;
            push_rsp(lfu_pkg::ST_OK, '0, 1'b1, 0);
            return;
        end
        if (!shadow_on)
        begin
            push_rsp(lfu_pkg::ST_OFF, '0, 1'b1, 0);
            return;
        end
        if (r.op == lfu_pkg::OP_LOOKUP)
        begin
            shadow_lookups = sat_inc(shadow_lookups);
            for (int i = 0; i < n; i++)
            begin
                if (!shadow_valid[i]) break;
                if (shadow_disk[i] == r.disk && shadow_block[i] == r.block)
                begin
                    shadow_hits = sat_inc(shadow_hits);
                    shadow_uses[i] = sat_inc(shadow_uses[i]);
                    for (int k = 0; k < WORDS; k++)
                        push_rsp(lfu_pkg::ST_OK, shadow_store[i][k], k == WORDS - 1, i);
                    return;
                end
            end
            push_rsp(lfu_pkg::ST_MISS, '0, 1'b1, 0);
            return;
        end
        if (r.op == lfu_pkg::OP_UPDATE)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (shadow_valid[i] && shadow_disk[i] == r.disk && shadow_block[i] == r.block)
                begin
                    shadow_store[i] = shadow_staging;
                    shadow_uses[i] = sat_inc(shadow_uses[i]);
                    push_rsp(lfu_pkg::ST_OK, '0, 1'b1, i);
                    return;
                end
            end
            push_rsp(lfu_pkg::ST_MISS, '0, 1'b1, 0);
            return;
        end
        // insert: first empty slot, else first slot with the fewest uses
        have_empty = 1'b0;
        empty = 0;
        victim = 0;
        for (int i = 0; i < n; i++)
        begin
            if (shadow_valid[i])
            begin
                if (shadow_disk[i] == r.disk && shadow_block[i] == r.block)
                begin
                    push_rsp(lfu_pkg::ST_DUP, '0, 1'b1, i);
                    return;
                end
                if (!shadow_valid[victim] || shadow_uses[i] < shadow_uses[victim])
                    victim = i;
            end
            else if (!have_empty)
            begin
                have_empty = 1'b1;
                empty = i;
            end
        end
        target = have_empty ? empty : victim;
        shadow_valid[target] = 1'b1;
        shadow_disk[target]  = r.disk;
        shadow_block[target] = r.block;
        shadow_uses[target]  = 32'd1;
        shadow_store[target] = shadow_staging;
        push_rsp(lfu_pkg::ST_OK, '0, 1'b1, target);
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                lfu_pkg::rsp_t want;
                want = pending_rsp.pop_front();
                if (want.status == lfu_pkg::ST_OK && want.read_word != 0) hit_results++;
                if (out_data.status !== want.status || out_data.read_word !== want.read_word
                    || out_data.last !== want.last || out_data.slot !== want.slot
                    || out_data.query_count !== want.query_count
                    || out_data.hit_count !== want.hit_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic set_pressure(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
        endcase
    endtask

    task automatic send_request(lfu_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        predict_cache(r);
        requests_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [lfu_pkg::CFG_IDX_W-1:0] idx,
                             logic [lfu_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == lfu_pkg::CFG_CACHE_ON)
        begin
            shadow_on = v[0];
            foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
            shadow_lookups = '0;
            shadow_hits = '0;
        end
        else
            shadow_entries = v;
    endtask

    function automatic lfu_pkg::req_t make_req(lfu_pkg::op_t op, int d, int b, int w,
                                               logic [63:0] data);
        lfu_pkg::req_t r;
        r.op = op;
        r.disk = d[3:0];
        r.block = b[7:0];
        r.word_index = w[4:0];
        r.data_word = data;
        return r;
    endfunction

    function automatic lfu_pkg::req_t random_req();
        int           pick;
        lfu_pkg::op_t op;
        pick = $urandom_range(99);
        op = (pick < 40) ? lfu_pkg::OP_STAGE : (pick < 65) ? lfu_pkg::OP_LOOKUP
            : (pick < 80) ? lfu_pkg::OP_UPDATE : lfu_pkg::OP_INSERT;
        // mostly a small key pool so hits, duplicates and evictions occur
        return make_req(op,
            ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(15),
            ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(255),
            $urandom_range(31), {$urandom, $urandom});
    endfunction

    task automatic test_disabled();
        // fill the whole staging buffer so every later commit is defined
        for (int w = 0; w < WORDS; w++)
            send_request(make_req(lfu_pkg::OP_STAGE, 0, 0, w,
                (w == 0) ? 64'd0 : (w == 1) ? '1 : {$urandom, $urandom}));
        send_request(make_req(lfu_pkg::OP_LOOKUP, 15, 255, 0, '0));
        send_request(make_req(lfu_pkg::OP_UPDATE, 1, 1, 0, '0));
        send_request(make_req(lfu_pkg::OP_INSERT, 1, 1, 0, '0));
        drain();
    endtask

    task automatic test_directed();
        write_reg(lfu_pkg::CFG_CACHE_ON, 9'd1);
        write_reg(lfu_pkg::CFG_ENTRIES, 9'd0);   // below range acts as 2
        send_request(make_req(lfu_pkg::OP_LOOKUP, 0, 0, 0, '0));     // miss on empty cache
        send_request(make_req(lfu_pkg::OP_INSERT, 0, 0, 0, '0));
        send_request(make_req(lfu_pkg::OP_INSERT, 0, 0, 0, '0));     // duplicate
        send_request(make_req(lfu_pkg::OP_LOOKUP, 0, 0, 0, '0));     // hit
        send_request(make_req(lfu_pkg::OP_STAGE, 0, 0, 31, '1));
        send_request(make_req(lfu_pkg::OP_UPDATE, 0, 0, 0, '0));
        send_request(make_req(lfu_pkg::OP_UPDATE, 15, 255, 0, '0));  // miss
        send_request(make_req(lfu_pkg::OP_INSERT, 15, 255, 0, '0));
        send_request(make_req(lfu_pkg::OP_INSERT, 7, 128, 0, '0));   // evicts fewest uses
        send_request(make_req(lfu_pkg::OP_LOOKUP, 7, 128, 0, '0));
        send_request(make_req(lfu_pkg::OP_LOOKUP, 15, 255, 0, '0));
        drain();
        write_reg(lfu_pkg::CFG_ENTRIES, 9'd511); // above range acts as 256
        send_request(make_req(lfu_pkg::OP_INSERT, 10, 85, 0, '0));
        send_request(make_req(lfu_pkg::OP_LOOKUP, 10, 85, 0, '0));
        drain();
    endtask

    task automatic test_random(int entries, int mode, int count);
        set_pressure(mode);
        write_reg(lfu_pkg::CFG_ENTRIES, entries[8:0]);
        write_reg(lfu_pkg::CFG_CACHE_ON, 9'd1);
        for (int i = 0; i < count; i++)
            send_request(random_req());
        drain();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        hit_results = 0;
        shadow_on = 1'b0;
        shadow_entries = 9'd2;
        shadow_lookups = '0;
        shadow_hits = '0;
        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 1'b0;
            shadow_uses[i] = '0;
        end
        set_pressure(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled();
        test_directed();
        test_random(3, 0, 50);
        test_random(8, 1, 50);
        test_random(256, 2, 45);
        test_random(2, 3, 45);
        write_reg(lfu_pkg::CFG_CACHE_ON, 9'd0);
        test_random(5, 0, 10);

        $display("run: %0d requests sent, %0d results checked (%0d nonzero hit words)",
            requests_sent, results_seen, hit_results);
        $display("slot counts 0..511 and cache on/off written; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("[lfu_block_cache_controller_unit] OK");
        else
            $display("[lfu_block_cache_controller_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[lfu_block_cache_controller_unit] ERROR");
        $finish;
    end
endmodule
